// ----- hdl/sts_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package sts_pkg;

    localparam int WS_DEPTH = 32;
    localparam int WS_AW    = (WS_DEPTH > 1) ? $clog2(WS_DEPTH) : 1;
    localparam int WS_CW    = $clog2(WS_DEPTH + 1);

    localparam logic [7:0] CH_LF   = 8'h0A;
    localparam logic [7:0] CH_HASH = 8'h23;
    localparam logic [7:0] CH_NUL  = 8'h00;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SEP,
        S_FLUSH,
        S_CHAR,
        S_EOMNL,
        S_MARK
    } t_state;

    typedef struct packed {
        logic             sep;
        logic             chr;
        logic             eomnl;
        logic             mark;
        logic             ovf;
        logic [7:0]       byte_val;
        logic [WS_CW-1:0] cnt;
    } t_plan;

    typedef struct packed {
        logic   accept;
        logic   fire;
        logic   last;
        t_state src;
    } t_cmd;

    typedef struct packed {
        t_plan dec_plan;
        t_plan plan;
        logic  out_free;
        logic  flush_last;
    } t_status;

    function automatic logic [4:0] plan_vec(input t_plan p);
        plan_vec = {p.sep, (p.cnt != '0), p.chr, p.eomnl, p.mark};
    endfunction

    function automatic logic [4:0] stage_mask(input t_state s);
        case (s)
            S_SEP:   stage_mask = 5'b01111;
            S_FLUSH: stage_mask = 5'b00111;
            S_CHAR:  stage_mask = 5'b00011;
            S_EOMNL: stage_mask = 5'b00001;
            S_MARK:  stage_mask = 5'b00000;
            default: stage_mask = 5'b11111;
        endcase
    endfunction

    function automatic t_state pick_stage(input logic [4:0] v);
        if (v[4]) begin
            pick_stage = S_SEP;
        end else if (v[3]) begin
            pick_stage = S_FLUSH;
        end else if (v[2]) begin
            pick_stage = S_CHAR;
        end else if (v[1]) begin
            pick_stage = S_EOMNL;
        end else if (v[0]) begin
            pick_stage = S_MARK;
        end else begin
            pick_stage = S_IDLE;
        end
    endfunction

    function automatic logic is_ws(input logic [7:0] c);
        is_ws = (c == 8'h20) || (c == 8'h09) || (c == 8'h0A) || (c == 8'h0B) ||
                (c == 8'h0C) || (c == 8'h0D);
    endfunction

endpackage

`default_nettype wire

// ----- hdl/sts_if.sv -----
`timescale 1ns / 1ps
`default_nettype none

interface sts_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;
    logic       end_of_message;

    modport source (output valid, output in_byte, output end_of_message, input ready);
    modport sink   (input valid, input in_byte, input end_of_message, output ready);
endinterface

interface sts_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       out_valid;
    logic       last;
    logic       overflow;

    modport source (output valid, output out_byte, output out_valid, output last,
                    output overflow, input ready);
    modport sink   (input valid, input out_byte, input out_valid, input last,
                    input overflow, output ready);
endinterface

interface sts_cfg_if;
    logic valid;
    logic ready;
    logic data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

// ----- hdl/sts_ram.sv -----
`timescale 1ns / 1ps
`default_nettype none

module sts_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

// ----- hdl/sts_ctrl.sv -----
`timescale 1ns / 1ps
`default_nettype none

module sts_ctrl
    import sts_pkg::*;
(
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_in_valid,
    input  wire t_status i_status,
    output logic         o_in_ready,
    output t_cmd         o_cmd
);

    t_state r_state;
    t_state n_state;
    t_state after_stage;
    logic   flush_hold;
    logic   fire;

    assign after_stage = pick_stage(plan_vec(i_status.plan) & stage_mask(r_state));
    assign flush_hold  = (r_state == S_FLUSH) && !i_status.flush_last;
    assign fire        = (r_state != S_IDLE) && i_status.out_free;

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_state = pick_stage(plan_vec(i_status.dec_plan));
                end
            end
            S_SEP, S_FLUSH, S_CHAR, S_EOMNL, S_MARK: begin
                if (fire && !flush_hold) begin
                    n_state = after_stage;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_in_ready    = (r_state == S_IDLE);
        o_cmd.accept  = (r_state == S_IDLE) && i_in_valid;
        o_cmd.fire    = fire;
        o_cmd.last    = !flush_hold && (after_stage == S_IDLE);
        o_cmd.src     = r_state;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    a_fire_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.fire |-> !o_in_ready)
        else $error("result issued while idle");

    a_flush_stays: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FLUSH) && !fire |=> (r_state == S_FLUSH))
        else $error("flush left without issuing");

endmodule

`default_nettype wire

// ----- hdl/sts_dp.sv -----
`timescale 1ns / 1ps
`default_nettype none

module sts_dp
    import sts_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic [7:0] i_in_byte,
    input  wire logic       i_eom,
    input  wire logic       i_cfg_we,
    input  wire logic       i_cfg_data,
    input  wire logic       i_out_ready,
    input  wire t_cmd       i_cmd,
    output t_status         o_status,
    output logic            o_out_valid,
    output logic [7:0]      o_out_byte,
    output logic            o_out_bvalid,
    output logic            o_out_last,
    output logic            o_out_ovf
);

    logic             r_strip;
    logic             r_at_start, n_at_start;
    logic             r_skip, n_skip;
    logic             r_content, n_content;
    logic             r_blank, n_blank;
    logic             r_started, n_started;
    logic [WS_CW-1:0] r_cnt, n_cnt;
    logic             r_ovf_seen, n_ovf_seen;
    t_plan            r_plan, n_plan;
    logic [WS_CW-1:0] r_idx;
    logic [WS_CW-1:0] idx_inc;
    logic [WS_CW-1:0] room;
    logic             wr_en;
    logic             flush_fire;
    logic [WS_AW-1:0] rd_addr;
    logic [7:0]       rd_data;
    logic             r_ovalid;
    logic [7:0]       r_obyte;
    logic             r_obvalid;
    logic             r_olast;
    logic             r_oovf;
    logic [7:0]       emit_byte;

    always_comb begin
        n_at_start = r_at_start;
        n_skip     = r_skip;
        n_content  = r_content;
        n_blank    = r_blank;
        n_started  = r_started;
        n_cnt      = r_cnt;
        n_ovf_seen = r_ovf_seen;
        wr_en      = 1'b0;
        n_plan     = '0;
        n_plan.byte_val = i_in_byte;
        room = (!r_content && r_blank && r_started) ? WS_CW'(WS_DEPTH - 1)
                                                    : WS_CW'(WS_DEPTH);
        if (r_at_start && r_strip && (i_in_byte == CH_HASH)) begin
            n_at_start = 1'b0;
            n_skip     = 1'b1;
        end else if (r_skip) begin
            if (i_in_byte == CH_LF) begin
                n_skip     = 1'b0;
                n_at_start = 1'b1;
            end
        end else begin
            n_at_start = 1'b0;
            if (i_in_byte == CH_LF) begin
                if (r_content) begin
                    n_plan.chr = 1'b1;
                end else begin
                    n_blank = 1'b1;
                end
                n_cnt      = '0;
                n_content  = 1'b0;
                n_at_start = 1'b1;
            end else if (is_ws(i_in_byte)) begin
                if (r_cnt < room) begin
                    wr_en = 1'b1;
                    n_cnt = r_cnt + 1'b1;
                end else begin
                    n_ovf_seen = 1'b1;
                end
            end else begin
                if (!r_content) begin
                    n_plan.sep = r_blank && r_started;
                    n_blank    = 1'b0;
                    n_content  = 1'b1;
                end
                n_plan.cnt = r_cnt;
                n_cnt      = '0;
                n_plan.chr = 1'b1;
                n_started  = 1'b1;
            end
        end
        n_plan.ovf = n_ovf_seen;
        if (i_eom) begin
            n_plan.eomnl = !n_at_start && !n_skip && n_content;
            n_plan.mark  = !(n_plan.sep || (n_plan.cnt != '0) || n_plan.chr ||
                             n_plan.eomnl);
            n_at_start = 1'b1;
            n_skip     = 1'b0;
            n_content  = 1'b0;
            n_blank    = 1'b0;
            n_started  = 1'b0;
            n_cnt      = '0;
            n_ovf_seen = 1'b0;
        end
    end

    assign idx_inc    = r_idx + 1'b1;
    assign flush_fire = i_cmd.fire && (i_cmd.src == S_FLUSH);
    assign rd_addr    = i_cmd.accept ? '0 : (flush_fire ? idx_inc[WS_AW-1:0]
                                                        : r_idx[WS_AW-1:0]);

    sts_ram #(
        .WIDTH (8),
        .DEPTH (WS_DEPTH)
    ) u_ws_ram (
        .i_clk   (i_clk),
        .i_we    (i_cmd.accept && wr_en),
        .i_waddr (r_cnt[WS_AW-1:0]),
        .i_wdata (i_in_byte),
        .i_raddr (rd_addr),
        .o_rdata (rd_data)
    );

    always_comb begin
        case (i_cmd.src)
            S_SEP:   emit_byte = CH_LF;
            S_EOMNL: emit_byte = CH_LF;
            S_FLUSH: emit_byte = rd_data;
            S_CHAR:  emit_byte = r_plan.byte_val;
            S_MARK:  emit_byte = CH_NUL;
            default: emit_byte = CH_NUL;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_strip    <= 1'b0;
            r_at_start <= 1'b1;
            r_skip     <= 1'b0;
            r_content  <= 1'b0;
            r_blank    <= 1'b0;
            r_started  <= 1'b0;
            r_cnt      <= '0;
            r_ovf_seen <= 1'b0;
            r_ovalid   <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_strip <= i_cfg_data;
            end
            if (i_cmd.accept) begin
                r_at_start <= n_at_start;
                r_skip     <= n_skip;
                r_content  <= n_content;
                r_blank    <= n_blank;
                r_started  <= n_started;
                r_cnt      <= n_cnt;
                r_ovf_seen <= n_ovf_seen;
            end
            if (i_cmd.fire) begin
                r_ovalid <= 1'b1;
            end else if (i_out_ready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_plan <= n_plan;
            r_idx  <= '0;
        end else if (flush_fire) begin
            r_idx <= idx_inc;
        end
        if (i_cmd.fire) begin
            r_obyte   <= emit_byte;
            r_obvalid <= (i_cmd.src != S_MARK);
            r_olast   <= i_cmd.last;
            r_oovf    <= r_plan.ovf;
        end
    end

    assign o_status.dec_plan   = n_plan;
    assign o_status.plan       = r_plan;
    assign o_status.out_free   = !r_ovalid || i_out_ready;
    assign o_status.flush_last = (idx_inc == r_plan.cnt);

    assign o_out_valid  = r_ovalid;
    assign o_out_byte   = r_obyte;
    assign o_out_bvalid = r_obvalid;
    assign o_out_last   = r_olast;
    assign o_out_ovf    = r_oovf;

    a_wr_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.accept && wr_en |-> (r_cnt < WS_CW'(WS_DEPTH)))
        else $error("held whitespace written past buffer");

    a_flush_idx: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        flush_fire |-> (r_idx < r_plan.cnt))
        else $error("flush index beyond held count");

    a_eom_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.accept && i_eom |=> (r_cnt == '0) && r_at_start && !r_ovf_seen)
        else $error("message state not cleared at end of message");

    a_mark_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.fire && (i_cmd.src == S_MARK) |-> i_cmd.last)
        else $error("end marker not flagged last");

endmodule

`default_nettype wire

// ----- hdl/text_stripspace_filter.sv -----
// On acceptance the plan and control state are registered; each result is then registered in
//   the output register when the output is free. New bytes are accepted only while idle.
// Results: separator newline, flushed held whitespace (up to WS_DEPTH, read from the RAM one
//   entry a cycle while output is free), the byte itself, a closing newline, or an end marker.
// Reset: synchronous, active low; clears line state, counts, the strip flag and output valid;
//   the whitespace RAM is not cleared and is read only where written.
`timescale 1ns / 1ps
`default_nettype none

module text_stripspace_filter
    import sts_pkg::*;
(
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    sts_in_if.sink     i_in,
    sts_cfg_if.sink    i_cfg,
    sts_out_if.source  o_out
);

    t_cmd    cmd;
    t_status status;
    logic    in_ready;

    assign i_in.ready  = in_ready;
    assign i_cfg.ready = 1'b1;

    sts_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .i_status   (status),
        .o_in_ready (in_ready),
        .o_cmd      (cmd)
    );

    sts_dp u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_byte    (i_in.in_byte),
        .i_eom        (i_in.end_of_message),
        .i_cfg_we     (i_cfg.valid),
        .i_cfg_data   (i_cfg.data),
        .i_out_ready  (o_out.ready),
        .i_cmd        (cmd),
        .o_status     (status),
        .o_out_valid  (o_out.valid),
        .o_out_byte   (o_out.out_byte),
        .o_out_bvalid (o_out.out_valid),
        .o_out_last   (o_out.last),
        .o_out_ovf    (o_out.overflow)
    );

endmodule

`default_nettype wire

// ----- tb/sv/tb_text_stripspace_filter.sv -----
`timescale 1ns / 1ps

module tb_text_stripspace_filter;
    import sts_pkg::*;

    localparam int STALL_LIMIT = 3000;
    localparam int HOLD_CYCLES = 300;
    localparam int SETTLE_CYCLES = WS_DEPTH + 8;
    localparam int PHASE_ITEMS = 110;

    typedef struct packed {
        logic [7:0] byte_val;
        logic       has_byte;
        logic       last;
        logic       ovf;
    } t_clean_res;

    logic i_clk = 1'b0;
    logic i_rst_n;

    sts_in_if  in_if();
    sts_cfg_if cfg_if();
    sts_out_if out_if();

    text_stripspace_filter dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .i_cfg   (cfg_if),
        .o_out   (out_if)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // cleanup predictor state
    logic       strip_hash;
    logic       line_start;
    logic       in_comment;
    logic       line_has_text;
    logic       blanks_pending;
    logic       text_started;
    logic [7:0] held_ws [WS_DEPTH];
    int         held_cnt;
    logic       ws_overflow;

    t_clean_res cleaned_q[$];
    logic [7:0] msg_q[$];

    int src_idle_pct;
    int sink_idle_pct;
    int hold_reqs;
    int items_sent;
    int errors;
    int stall_cycles;
    t_clean_res want;

    function automatic logic is_space_char(input logic [7:0] c);
        case (c)
            8'h09, 8'h0A, 8'h0B, 8'h0C, 8'h0D, 8'h20: return 1'b1;
            default: return 1'b0;
        endcase
    endfunction

    function automatic logic [7:0] rand_hspace();
        case ($urandom_range(0, 5))
            0: return 8'h09;
            1: return 8'h0B;
            2: return 8'h0C;
            3: return 8'h0D;
            default: return 8'h20;
        endcase
    endfunction

    function automatic logic [7:0] rand_text_char();
        logic [7:0] c;
        do c = 8'($urandom_range(0, 255)); while (is_space_char(c));
        return c;
    endfunction

    task automatic clear_line_state();
        line_start     = 1'b1;
        in_comment     = 1'b0;
        line_has_text  = 1'b0;
        blanks_pending = 1'b0;
        text_started   = 1'b0;
        held_cnt       = 0;
        ws_overflow    = 1'b0;
    endtask

    task automatic clean_byte(input logic [7:0] c, input logic eom);
        t_clean_res res[$];
        int room;
        if (line_start && strip_hash && c == CH_HASH) begin
            line_start = 1'b0;
            in_comment = 1'b1;
        end else if (in_comment) begin
            if (c == CH_LF) begin
                in_comment = 1'b0;
                line_start = 1'b1;
            end
        end else begin
            line_start = 1'b0;
            if (c == CH_LF) begin
                if (line_has_text) begin
                    res.push_back('{CH_LF, 1'b1, 1'b0, 1'b0});
                end else begin
                    blanks_pending = 1'b1;
                end
                held_cnt = 0;
                line_has_text = 1'b0;
                line_start = 1'b1;
            end else if (is_space_char(c)) begin
                room = (!line_has_text && blanks_pending && text_started) ? WS_DEPTH - 1
                                                                           : WS_DEPTH;
                if (held_cnt < room) begin
                    held_ws[held_cnt] = c;
                    held_cnt++;
                end else begin
                    ws_overflow = 1'b1;
                end
            end else begin
                if (!line_has_text) begin
                    if (blanks_pending && text_started) begin
                        res.push_back('{CH_LF, 1'b1, 1'b0, 1'b0});
                    end
                    blanks_pending = 1'b0;
                    line_has_text = 1'b1;
                end
                for (int i = 0; i < held_cnt; i++) begin
                    res.push_back('{held_ws[i], 1'b1, 1'b0, 1'b0});
                end
                held_cnt = 0;
                res.push_back('{c, 1'b1, 1'b0, 1'b0});
                text_started = 1'b1;
            end
        end

        if (eom) begin
            if (!line_start && !in_comment && line_has_text) begin
                res.push_back('{CH_LF, 1'b1, 1'b0, 1'b0});
            end
            if (res.size() == 0) begin
                res.push_back('{CH_NUL, 1'b0, 1'b0, 1'b0});
            end
        end

        foreach (res[i]) begin
            res[i].ovf = ws_overflow;
            res[i].last = (i == res.size() - 1);
            cleaned_q.push_back(res[i]);
        end

        if (eom) begin
            clear_line_state();
        end
    endtask

    task automatic send_byte(input logic [7:0] b, input logic eom);
        while ($urandom_range(0, 99) < src_idle_pct) begin
            in_if.valid <= 1'b0;
            @(negedge i_clk);
        end
        in_if.valid          <= 1'b1;
        in_if.in_byte        <= b;
        in_if.end_of_message <= eom;
        do @(posedge i_clk); while (!in_if.ready);
        clean_byte(b, eom);
        items_sent++;
        @(negedge i_clk);
    endtask

    task automatic send_message();
        foreach (msg_q[i]) begin
            send_byte(msg_q[i], i == msg_q.size() - 1);
        end
    endtask

    task automatic settle_idle();
        in_if.valid <= 1'b0;
        while (cleaned_q.size() != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic set_comment_strip(input logic en);
        settle_idle();
        cfg_if.valid <= 1'b1;
        cfg_if.data  <= en;
        do @(posedge i_clk); while (!cfg_if.ready);
        strip_hash = en;
        @(negedge i_clk);
        cfg_if.valid <= 1'b0;
    endtask

    task automatic add_word();
        repeat ($urandom_range(1, 5)) msg_q.push_back(rand_text_char());
    endtask

    task automatic add_text_line(input logic with_lf);
        int kind;
        int n;
        kind = $urandom_range(0, 11);
        if (kind < 2) begin
            repeat ($urandom_range(0, 3)) msg_q.push_back(rand_hspace());
        end else if (kind == 2) begin
            msg_q.push_back(CH_HASH);
            add_word();
        end else begin
            if (kind == 3) begin
                n = $urandom_range(WS_DEPTH - 4, WS_DEPTH + 3);
            end else begin
                n = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 2) : 0;
            end
            repeat (n) msg_q.push_back(rand_hspace());
            if (kind == 4) begin
                msg_q.push_back(CH_HASH);
            end
            n = $urandom_range(1, 3);
            for (int w = 0; w < n; w++) begin
                if (w != 0) begin
                    repeat ($urandom_range(1, 2)) msg_q.push_back(rand_hspace());
                end
                add_word();
            end
            repeat ($urandom_range(0, 3)) msg_q.push_back(rand_hspace());
        end
        if (with_lf) begin
            msg_q.push_back(CH_LF);
        end
    endtask

    task automatic make_text_message();
        int lines;
        msg_q.delete();
        lines = $urandom_range(1, 4);
        for (int i = 0; i < lines; i++) begin
            add_text_line(i < lines - 1 || $urandom_range(0, 1) == 0);
        end
        if (msg_q.size() == 0) begin
            msg_q.push_back(CH_LF);
        end
    endtask

    task automatic make_noise_message();
        msg_q.delete();
        repeat ($urandom_range(3, 12)) begin
            case ($urandom_range(0, 5))
                0: msg_q.push_back(CH_LF);
                1: msg_q.push_back(CH_HASH);
                2: msg_q.push_back(rand_hspace());
                default: msg_q.push_back(8'($urandom_range(0, 255)));
            endcase
        end
    endtask

    task automatic test_byte_extremes();
        set_comment_strip(1'b0);
        msg_q = '{CH_NUL, 8'h20, 8'hFF};
        send_message();
        msg_q = '{CH_LF};
        send_message();
    endtask

    task automatic test_blank_lines();
        msg_q = '{CH_LF, 8'h20, CH_LF, 8'h61, 8'h62, 8'h20, CH_LF, CH_LF, 8'h63, 8'h64, 8'h09};
        send_message();
    endtask

    task automatic test_comment_lines();
        set_comment_strip(1'b1);
        msg_q = '{CH_HASH, 8'h78, CH_LF, 8'h20, CH_HASH, CH_LF, CH_HASH};
        send_message();
    endtask

    task automatic test_ws_overflow();
        msg_q.delete();
        msg_q.push_back(8'h61);
        repeat (WS_DEPTH + 2) msg_q.push_back(rand_hspace());
        msg_q.push_back(8'h62);
        send_message();
        msg_q = '{8'h61, CH_LF, CH_LF};
        repeat (WS_DEPTH + 1) msg_q.push_back(rand_hspace());
        msg_q.push_back(8'h63);
        send_message();
    endtask

    task automatic test_output_backpressure();
        hold_reqs++;
        msg_q.delete();
        repeat (3) begin
            add_word();
            repeat (8) msg_q.push_back(rand_hspace());
            add_word();
            msg_q.push_back(CH_LF);
        end
        send_message();
    endtask

    task automatic run_random_phase(input int src_pct, input int sink_pct, input logic strip);
        int first;
        src_idle_pct  = src_pct;
        sink_idle_pct = sink_pct;
        set_comment_strip(strip);
        first = items_sent;
        while (items_sent - first < PHASE_ITEMS) begin
            if ($urandom_range(0, 5) == 0) begin
                make_noise_message();
            end else begin
                make_text_message();
            end
            send_message();
        end
    endtask

    task automatic check_field(input string name, input int exp_val, input int got_val);
        if (exp_val != got_val) begin
            errors++;
            $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, exp_val,
                     got_val);
        end
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && out_if.valid && out_if.ready) begin
            if (cleaned_q.size() == 0) begin
                errors++;
                $display("%0t: unexpected transaction, expected none, got %0h/%0b/%0b/%0b",
                         $time, out_if.out_byte, out_if.out_valid, out_if.last,
                         out_if.overflow);
            end else begin
                want = cleaned_q.pop_front();
                check_field("out_byte", want.byte_val, out_if.out_byte);
                check_field("out_valid", want.has_byte, out_if.out_valid);
                check_field("last", want.last, out_if.last);
                check_field("overflow", want.ovf, out_if.overflow);
            end
        end
    end

    initial begin
        int hold_left;
        int hold_seen;
        hold_left = 0;
        hold_seen = 0;
        out_if.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_seen != hold_reqs) begin
                hold_seen = hold_reqs;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                out_if.ready <= 1'b0;
            end else begin
                out_if.ready <= ($urandom_range(0, 99) >= sink_idle_pct);
            end
        end
    end

    always @(posedge i_clk) begin
        if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready) ||
            (cfg_if.valid && cfg_if.ready)) begin
            stall_cycles <= 0;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
        if (stall_cycles >= STALL_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    initial begin
        i_rst_n              = 1'b0;
        in_if.valid          = 1'b0;
        in_if.in_byte        = CH_NUL;
        in_if.end_of_message = 1'b0;
        cfg_if.valid         = 1'b0;
        cfg_if.data          = 1'b0;
        stall_cycles         = 0;
        errors               = 0;
        items_sent           = 0;
        hold_reqs            = 0;
        src_idle_pct         = 11;
        sink_idle_pct        = 59;
        strip_hash           = 1'b0;
        clear_line_state();

        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        test_byte_extremes();
        test_blank_lines();
        test_comment_lines();
        test_ws_overflow();
        test_output_backpressure();
        run_random_phase(11, 59, 1'b1);
        run_random_phase(59, 11, 1'b0);
        run_random_phase(0, 0, 1'b1);

        settle_idle();
        if (errors == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
